// ===== rtl/software_timer_pool_top_defines.svh =====
// -----------------------------------------------------------------------------
// Software timer pool assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_POOL_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_POOL_TOP_DEFINES_SVH

// Same-cycle implication.
`define STP_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STP_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stp_pkg.sv =====
// -----------------------------------------------------------------------------
// Software timer pool package
// Shared constants, operation and result codes, and controller/datapath structs.
// -----------------------------------------------------------------------------
package stp_pkg;

    localparam int POOL_DEF        = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FUNC_W          = 3;
    localparam int SLOT_FIELD_W    = 4;
    localparam int STORE_W         = 16;
    localparam int KIND_W          = 2;
    localparam int SLOT_SPAN       = 16;
    localparam int MAX_FIRE        = 16;
    localparam int FIRE_N_W        = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK    = 3'd0,
        FN_ACQUIRE = 3'd1,
        FN_RELEASE = 3'd2,
        FN_START   = 3'd3,
        FN_STOP    = 3'd4,
        FN_RESTART = 3'd5
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KD_DONE    = 2'd0,
        KD_FIRED   = 2'd1,
        KD_GRANTED = 2'd2,
        KD_FAILED  = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_item;
        logic  walk_clr;
        logic  walk_inc;
        logic  rd_issue;
        logic  eval;
        logic  grant;
        logic  slot_op;
        logic  emit;
        t_kind emit_kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              out_free;
        logic              walk_end;
        logic              acq_end;
        logic              cur_acq;
        logic              cur_active;
        logic              hold;
        logic              pend_valid;
    } t_sts;

endpackage

// ===== rtl/stp_ram.sv =====
// -----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// -----------------------------------------------------------------------------
module stp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stp_ctrl.sv =====
// -----------------------------------------------------------------------------
// Software timer pool controller
// Sequences decode, the acquire scan and the tick walk over the pool.
// -----------------------------------------------------------------------------
`include "software_timer_pool_top_defines.svh"

module stp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  stp_pkg::t_sts i_sts,
    output stp_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ACQ_SCAN,
        S_TICK_SCAN,
        S_TICK_EVAL
    } t_state;

    t_state        r_state;
    t_state        n_state;
    stp_pkg::t_cmd cmd;

    always_comb begin
        cmd           = '0;
        cmd.emit_kind = stp_pkg::KD_DONE;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.func)
                    stp_pkg::FN_TICK: begin
                        cmd.walk_clr = 1'b1;
                        n_state      = S_TICK_SCAN;
                    end
                    stp_pkg::FN_ACQUIRE: begin
                        cmd.walk_clr = 1'b1;
                        n_state      = S_ACQ_SCAN;
                    end
                    default: begin
                        if (i_sts.out_free) begin
                            cmd.slot_op = 1'b1;
                            cmd.emit    = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                endcase
            end
            S_ACQ_SCAN: begin
                if (i_sts.acq_end) begin
                    if (i_sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = stp_pkg::KD_FAILED;
                        n_state       = S_IDLE;
                    end
                end else if (!i_sts.cur_acq) begin
                    if (i_sts.out_free) begin
                        cmd.grant     = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = stp_pkg::KD_GRANTED;
                        n_state       = S_IDLE;
                    end
                end else begin
                    cmd.walk_inc = 1'b1;
                end
            end
            S_TICK_SCAN: begin
                if (i_sts.walk_end) begin
                    if (i_sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = i_sts.pend_valid ? stp_pkg::KD_FIRED
                                                         : stp_pkg::KD_DONE;
                        n_state       = S_IDLE;
                    end
                end else if (i_sts.cur_active) begin
                    cmd.rd_issue = 1'b1;
                    n_state      = S_TICK_EVAL;
                end else begin
                    cmd.walk_inc = 1'b1;
                end
            end
            S_TICK_EVAL: begin
                if (!i_sts.hold) begin
                    cmd.eval     = 1'b1;
                    cmd.walk_inc = 1'b1;
                    n_state      = S_TICK_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

    `STP_CHECK(a_emit_needs_room, cmd.emit, i_sts.out_free, "result emitted into a full output")
    `STP_CHECK_NEXT(a_accept_decodes, i_in_valid && (r_state == S_IDLE), r_state == S_DECODE, "accepted transaction not decoded")

endmodule

// ===== rtl/stp_dp.sv =====
// -----------------------------------------------------------------------------
// Software timer pool datapath
// Timer flags, period/repeat and counter memories, tick update and result register.
// -----------------------------------------------------------------------------
`include "software_timer_pool_top_defines.svh"

module stp_dp #(
    parameter int POOL        = stp_pkg::POOL_DEF,
    parameter int COUNT_WIDTH = stp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  stp_pkg::t_cmd                       i_cmd,
    output stp_pkg::t_sts                       o_sts,
    input  logic [stp_pkg::FUNC_W-1:0]          i_func,
    input  logic [stp_pkg::SLOT_FIELD_W-1:0]    i_slot,
    input  logic [stp_pkg::STORE_W-1:0]         i_period,
    input  logic signed [stp_pkg::STORE_W-1:0]  i_repeat_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [stp_pkg::KIND_W-1:0]          o_kind,
    output logic [stp_pkg::SLOT_FIELD_W-1:0]    o_slot_out,
    output logic                                o_last
);

    localparam int SLOT_W    = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int CNT_W     = $clog2(POOL + 1);
    localparam int ACQ_LIMIT = (POOL < stp_pkg::SLOT_SPAN) ? POOL : stp_pkg::SLOT_SPAN;
    localparam int CW        = COUNT_WIDTH;
    localparam int CMP_W     = (CW > stp_pkg::STORE_W) ? CW : stp_pkg::STORE_W;
    localparam int SW        = stp_pkg::STORE_W;

    // Captured transaction.
    logic [stp_pkg::FUNC_W-1:0]       r_func;
    logic [stp_pkg::SLOT_FIELD_W-1:0] r_slot;
    logic [SW-1:0]                    r_period;
    logic [SW-1:0]                    r_repeat;

    // Walk state and per-slot flags.
    logic [CNT_W-1:0]                 r_cnt;
    logic [POOL-1:0]                  r_acquired;
    logic [POOL-1:0]                  r_running;
    logic                             r_pend_valid;
    logic [stp_pkg::SLOT_FIELD_W-1:0] r_pend_slot;
    logic [stp_pkg::FIRE_N_W-1:0]     r_fire_n;

    // Result register.
    logic                             r_out_valid;
    logic [stp_pkg::KIND_W-1:0]       r_kind;
    logic [stp_pkg::SLOT_FIELD_W-1:0] r_slot_out;
    logic                             r_last;

    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_ok;
    logic              out_free;

    logic [2*SW-1:0]   cfg_rdata;
    logic [2*CW-1:0]   cnt_rdata;
    logic              cnt_we;
    logic [SLOT_W-1:0] cnt_waddr;
    logic [2*CW-1:0]   cnt_wdata;

    logic [SW-1:0] period_q;
    logic [SW-1:0] repeat_q;
    logic [CW-1:0] tc_q;
    logic [CW-1:0] lc_q;
    logic [CW-1:0] tc_inc;
    logic [CW-1:0] lc_inc;
    logic [CW-1:0] tc_n;
    logic [CW-1:0] lc_n;
    logic          fire;
    logic          finite;
    logic          stop_now;
    logic          room;
    logic          capture;
    logic          push;
    logic          out_load;
    logic          zero_counts;

    assign idx      = r_cnt[SLOT_W-1:0];
    assign slot_idx = SLOT_W'(r_slot);
    assign slot_ok  = (int'(r_slot) < POOL);
    assign out_free = !r_out_valid || !i_out_stall;

    // Per-slot timer evaluation on the registered memory read.
    assign period_q = cfg_rdata[2*SW-1:SW];
    assign repeat_q = cfg_rdata[SW-1:0];
    assign tc_q     = cnt_rdata[2*CW-1:CW];
    assign lc_q     = cnt_rdata[CW-1:0];
    assign tc_inc   = tc_q + 1'b1;
    assign lc_inc   = (lc_q == {CW{1'b1}}) ? lc_q : lc_q + 1'b1;
    assign fire     = (CMP_W'(tc_inc) == CMP_W'(period_q));
    assign finite   = !repeat_q[SW-1];
    assign stop_now = fire && finite && (CMP_W'(lc_inc) > CMP_W'(repeat_q));
    assign tc_n     = fire ? '0 : tc_inc;
    assign lc_n     = stop_now ? '0 : ((fire && finite) ? lc_inc : lc_q);

    assign room     = (r_fire_n < stp_pkg::FIRE_N_W'(stp_pkg::MAX_FIRE));
    assign capture  = i_cmd.eval && fire && room;
    assign push     = capture && r_pend_valid;
    assign out_load = push || i_cmd.emit;

    assign zero_counts = i_cmd.slot_op && slot_ok &&
                         ((r_func == stp_pkg::FN_STOP) || (r_func == stp_pkg::FN_RESTART));

    // Counter memory write selection.
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = idx;
        cnt_wdata = '0;
        if (i_cmd.eval) begin
            cnt_we    = 1'b1;
            cnt_wdata = {tc_n, lc_n};
        end else if (i_cmd.grant) begin
            cnt_we = 1'b1;
        end else if (zero_counts) begin
            cnt_we    = 1'b1;
            cnt_waddr = slot_idx;
        end
    end

    stp_ram #(
        .WIDTH (2 * SW),
        .DEPTH (POOL)
    ) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.grant),
        .i_waddr (idx),
        .i_wdata ({r_period, r_repeat}),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (idx),
        .o_rdata (cfg_rdata)
    );

    stp_ram #(
        .WIDTH (2 * CW),
        .DEPTH (POOL)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (idx),
        .o_rdata (cnt_rdata)
    );

    // Transaction capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func   <= i_func;
            r_slot   <= i_slot;
            r_period <= i_period;
            r_repeat <= i_repeat_count;
        end
    end

    // Flags, walk counter and pending fire.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acquired   <= '0;
            r_running    <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_fire_n     <= '0;
        end else begin
            if (i_cmd.walk_clr) begin
                r_cnt        <= '0;
                r_pend_valid <= 1'b0;
                r_fire_n     <= '0;
            end else if (i_cmd.walk_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (capture) begin
                r_pend_valid <= 1'b1;
                r_fire_n     <= r_fire_n + 1'b1;
            end
            if (i_cmd.grant) begin
                r_acquired[idx] <= 1'b1;
                r_running[idx]  <= 1'b0;
            end
            if (i_cmd.eval && stop_now) begin
                r_running[idx] <= 1'b0;
            end
            if (i_cmd.slot_op && slot_ok) begin
                case (r_func)
                    stp_pkg::FN_RELEASE: r_acquired[slot_idx] <= 1'b0;
                    stp_pkg::FN_START:   r_running[slot_idx]  <= 1'b1;
                    stp_pkg::FN_STOP:    r_running[slot_idx]  <= 1'b0;
                    stp_pkg::FN_RESTART: r_running[slot_idx]  <= 1'b1;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_pend_slot <= stp_pkg::SLOT_FIELD_W'(idx);
        end
    end

    // Result register: a pushed fire is never the last one of its tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind     <= stp_pkg::KD_FIRED;
            r_slot_out <= r_pend_slot;
            r_last     <= 1'b0;
        end else if (i_cmd.emit) begin
            r_kind <= i_cmd.emit_kind;
            r_last <= 1'b1;
            case (i_cmd.emit_kind)
                stp_pkg::KD_GRANTED: r_slot_out <= stp_pkg::SLOT_FIELD_W'(idx);
                stp_pkg::KD_FIRED:   r_slot_out <= r_pend_slot;
                default:             r_slot_out <= '0;
            endcase
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.func       = r_func;
        o_sts.out_free   = out_free;
        o_sts.walk_end   = (r_cnt == CNT_W'(POOL));
        o_sts.acq_end    = (r_cnt == CNT_W'(ACQ_LIMIT));
        o_sts.cur_acq    = r_acquired[idx];
        o_sts.cur_active = r_acquired[idx] && r_running[idx];
        o_sts.hold       = fire && room && r_pend_valid && !out_free;
        o_sts.pend_valid = r_pend_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_slot_out  = r_slot_out;
    assign o_last      = r_last;

    `STP_CHECK(a_no_overwrite, r_out_valid && i_out_stall, !out_load, "stalled result overwritten")
    `STP_CHECK(a_fire_cap, r_pend_valid, (r_fire_n != '0) && (r_fire_n <= stp_pkg::FIRE_N_W'(stp_pkg::MAX_FIRE)), "fire count out of range")
    `STP_CHECK_NEXT(a_capture_pends, capture, r_pend_valid, "captured fire not pending")

endmodule

// ===== rtl/software_timer_pool_top.sv =====
// -----------------------------------------------------------------------------
// Software timer pool
// Pool of POOL software timers with acquire, release, start, stop, restart and tick.
// -----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_func, i_slot, i_period, i_repeat_count
//  out      | output    | o_out_valid / i_out_stall | o_kind, o_slot_out, o_last
//
//  Release, start, stop, restart and unknown operations finish in the decode state.
//  Acquire scans the acquired flags one slot per cycle, over at most min(POOL, 16) slots.
//  Tick walks every slot: an idle slot is only stepped past, and a running one
//  takes a memory read, then update and write back.
//  Reset is synchronous and active low; it clears the flags, the controller and the
//  output valid. Memories need no clearing since acquire loads every field it reads.
//  A stalled output holds its transaction; the walk pauses until the register frees.
// -----------------------------------------------------------------------------
module software_timer_pool_top #(
    parameter int POOL        = stp_pkg::POOL_DEF,
    parameter int COUNT_WIDTH = stp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Operation channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [stp_pkg::FUNC_W-1:0]         i_func,
    input  logic [stp_pkg::SLOT_FIELD_W-1:0]   i_slot,
    input  logic [stp_pkg::STORE_W-1:0]        i_period,
    input  logic signed [stp_pkg::STORE_W-1:0] i_repeat_count,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [stp_pkg::KIND_W-1:0]         o_kind,
    output logic [stp_pkg::SLOT_FIELD_W-1:0]   o_slot_out,
    output logic                               o_last
);

    // The controller only sequences; all state the operations touch lives
    // in the datapath, and the two talk through the command and status structs.
    stp_pkg::t_cmd cmd;
    stp_pkg::t_sts sts;

    stp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath owns the result register, so a finished result can wait
    // there while the controller already takes the next transaction.
    stp_dp #(
        .POOL        (POOL),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_period       (i_period),
        .i_repeat_count (i_repeat_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_slot_out     (o_slot_out),
        .o_last         (o_last)
    );

endmodule

// ===== dv/software_timer_pool_top_test.sv =====
// -----------------------------------------------------------------------------
// Software timer pool testbench
// Drives tick, acquire, release, start, stop and restart operations into the
// timer pool and checks every result transaction against a cycle-free timer
// predictor, under random sender gaps and receiver stalls.
// -----------------------------------------------------------------------------
module software_timer_pool_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Function codes outside the defined set; the block must treat them as no-ops.
    localparam logic [stp_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [stp_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 300;
    localparam int ERROR_PRINTS = 40;

    // One result transaction as the block should present it.
    typedef struct packed {
        stp_pkg::t_kind                   kind;
        logic [stp_pkg::SLOT_FIELD_W-1:0] slot;
        logic                             last;
    } t_pool_event;

    // One row of the opening walkthrough. When has_typed is set the single
    // result is written out in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [stp_pkg::FUNC_W-1:0]       func;
        logic [stp_pkg::SLOT_FIELD_W-1:0] slot;
        logic [stp_pkg::STORE_W-1:0]      period;
        logic [stp_pkg::STORE_W-1:0]      reps;
        logic                             has_typed;
        stp_pkg::t_kind                   kind;
        logic [stp_pkg::SLOT_FIELD_W-1:0] slot_out;
    } t_plan_row;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic [stp_pkg::FUNC_W-1:0]         i_func;
    logic [stp_pkg::SLOT_FIELD_W-1:0]   i_slot;
    logic [stp_pkg::STORE_W-1:0]        i_period;
    logic signed [stp_pkg::STORE_W-1:0] i_repeat_count;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic [stp_pkg::KIND_W-1:0]         o_kind;
    logic [stp_pkg::SLOT_FIELD_W-1:0]   o_slot_out;
    logic                               o_last;

    software_timer_pool_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_period       (i_period),
        .i_repeat_count (i_repeat_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_slot_out     (o_slot_out),
        .o_last         (o_last)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // -------------------------------------------------------------------------
    // Timer predictor state. It mirrors what the pool should hold after every
    // accepted operation transaction.
    // -------------------------------------------------------------------------
    bit                          slot_acquired [stp_pkg::POOL_DEF];
    bit                          slot_running  [stp_pkg::POOL_DEF];
    logic [stp_pkg::STORE_W-1:0] slot_period   [stp_pkg::POOL_DEF];
    logic [stp_pkg::STORE_W-1:0] slot_reps     [stp_pkg::POOL_DEF];
    logic [stp_pkg::STORE_W-1:0] slot_ticks    [stp_pkg::POOL_DEF];
    logic [stp_pkg::STORE_W-1:0] slot_loops    [stp_pkg::POOL_DEF];

    // Results of the most recent predicted operation, in output order.
    t_pool_event step_events [stp_pkg::MAX_FIRE];

    // Results that the block still owes, oldest first.
    t_pool_event owed_results [$];

    int  error_count    = 0;
    int  ops_sent       = 0;
    int  results_seen   = 0;
    int  fired_seen     = 0;
    int  granted_seen   = 0;
    int  refused_seen   = 0;
    int  widest_tick    = 0;
    int  burst_left     = 0;
    bit  long_hold_due  = 1'b0;
    int unsigned cycle_count = 0;

    // The opening walkthrough: unacquired slots first, then acquires at the
    // field extremes, one-shot, two-shot, forever and near-forever timers,
    // release and re-acquire, and the two undefined function codes.
    t_plan_row opening_plan [0:24] = '{
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_START,   4'd3, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_RESTART, 4'd9, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_STOP,    4'd9, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_ACQUIRE, 4'd0, 16'd1,    16'd0,    1'b1, stp_pkg::KD_GRANTED, 4'd0},
        '{stp_pkg::FN_ACQUIRE, 4'd0, 16'hFFFF, 16'hFFFF, 1'b1, stp_pkg::KD_GRANTED, 4'd1},
        '{stp_pkg::FN_ACQUIRE, 4'd0, 16'd2,    16'h7FFF, 1'b1, stp_pkg::KD_GRANTED, 4'd2},
        '{stp_pkg::FN_ACQUIRE, 4'd0, 16'd1,    16'd1,    1'b1, stp_pkg::KD_GRANTED, 4'd3},
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_START,   4'd0, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_START,   4'd1, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_START,   4'd2, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b0, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b0, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_START,   4'd3, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b0, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_RESTART, 4'd2, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_STOP,    4'd1, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_RELEASE, 4'd0, 16'd0,    16'd0,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{FN_SPARE_A,          4'd5, 16'd7,    16'd7,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{FN_SPARE_B,         4'd15, 16'd1,    16'd1,    1'b1, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_ACQUIRE, 4'd0, 16'd5,    16'd3,    1'b1, stp_pkg::KD_GRANTED, 4'd0},
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b0, stp_pkg::KD_DONE,    4'd0},
        '{stp_pkg::FN_TICK,    4'd0, 16'd0,    16'd0,    1'b0, stp_pkg::KD_DONE,    4'd0}
    };

    function automatic void halt_timer(int s);
        slot_running[s] = 1'b0;
        slot_ticks[s]   = '0;
        slot_loops[s]   = '0;
    endfunction

    // Applies one operation to the predictor state and leaves its results in
    // step_events. Returns how many results the operation causes.
    function automatic int advance_pool(logic [stp_pkg::FUNC_W-1:0] func,
                                        logic [stp_pkg::SLOT_FIELD_W-1:0] slot,
                                        logic [stp_pkg::STORE_W-1:0] period,
                                        logic [stp_pkg::STORE_W-1:0] reps);
        int n;
        bit granted;
        n = 0;
        granted = 1'b0;
        if (func == stp_pkg::FN_TICK) begin
            for (int s = 0; s < stp_pkg::POOL_DEF; s++) begin
                if (!(slot_acquired[s] && slot_running[s]))
                    continue;
                // The tick counter wraps at its width.
                slot_ticks[s] = slot_ticks[s] + 16'd1;
                if (slot_ticks[s] != slot_period[s])
                    continue;
                step_events[n] = '{stp_pkg::KD_FIRED, stp_pkg::SLOT_FIELD_W'(s), 1'b0};
                n++;
                slot_ticks[s] = '0;
                // A negative repeat count means the timer never runs out.
                if (!slot_reps[s][stp_pkg::STORE_W-1]) begin
                    if (slot_loops[s] != 16'hFFFF)
                        slot_loops[s] = slot_loops[s] + 16'd1;
                    if (slot_loops[s] > slot_reps[s])
                        halt_timer(s);
                end
            end
            if (n > widest_tick)
                widest_tick = n;
            if (n == 0) begin
                step_events[0] = '{stp_pkg::KD_DONE, '0, 1'b1};
                n = 1;
            end else begin
                step_events[n-1].last = 1'b1;
            end
        end else if (func == stp_pkg::FN_ACQUIRE) begin
            step_events[0] = '{stp_pkg::KD_FAILED, '0, 1'b1};
            for (int s = 0; s < stp_pkg::POOL_DEF && s < stp_pkg::SLOT_SPAN; s++) begin
                if (!granted && !slot_acquired[s]) begin
                    granted          = 1'b1;
                    slot_period[s]   = period;
                    slot_reps[s]     = reps;
                    halt_timer(s);
                    slot_acquired[s] = 1'b1;
                    step_events[0]   = '{stp_pkg::KD_GRANTED, stp_pkg::SLOT_FIELD_W'(s), 1'b1};
                end
            end
            n = 1;
        end else begin
            // With POOL at 16 every slot field value names a real slot. The
            // slot ops act on the flags whether or not the slot is acquired.
            if (func == stp_pkg::FN_RELEASE)
                slot_acquired[slot] = 1'b0;
            else if (func == stp_pkg::FN_START)
                slot_running[slot] = 1'b1;
            else if (func == stp_pkg::FN_STOP)
                halt_timer(slot);
            else if (func == stp_pkg::FN_RESTART) begin
                halt_timer(slot);
                slot_running[slot] = 1'b1;
            end
            step_events[0] = '{stp_pkg::KD_DONE, '0, 1'b1};
            n = 1;
        end
        return n;
    endfunction

    // Offers one operation, holds it until the block takes it, then records
    // what the block now owes. Gaps between bursts are inserted afterwards.
    task automatic issue_op(logic [stp_pkg::FUNC_W-1:0] func,
                            logic [stp_pkg::SLOT_FIELD_W-1:0] slot,
                            logic [stp_pkg::STORE_W-1:0] period,
                            logic [stp_pkg::STORE_W-1:0] reps,
                            bit has_typed, t_pool_event typed_ev);
        int n;
        int gap;
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_slot         <= slot;
        i_period       <= period;
        i_repeat_count <= reps;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        ops_sent++;
        n = advance_pool(func, slot, period, reps);
        if (has_typed)
            owed_results.push_back(typed_ev);
        else
            for (int k = 0; k < n; k++)
                owed_results.push_back(step_events[k]);

        // Burst pacing: a random run of back-to-back transactions, then an
        // optional random gap. A zero gap chains bursts into long busy stretches.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Random operation with content biased toward slots that are acquired, so
    // that most start, stop, restart and release transactions hit live timers.
    task automatic issue_random_op();
        int pick;
        int base;
        logic [stp_pkg::FUNC_W-1:0]       func;
        logic [stp_pkg::SLOT_FIELD_W-1:0] slot;
        logic [stp_pkg::STORE_W-1:0]      period;
        logic [stp_pkg::STORE_W-1:0]      reps;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            func = stp_pkg::FN_TICK;
        else if (pick < 50)
            func = stp_pkg::FN_ACQUIRE;
        else if (pick < 68)
            func = stp_pkg::FN_START;
        else if (pick < 76)
            func = stp_pkg::FN_STOP;
        else if (pick < 84)
            func = stp_pkg::FN_RESTART;
        else if (pick < 96)
            func = stp_pkg::FN_RELEASE;
        else
            func = ($urandom_range(0, 1) == 0) ? FN_SPARE_A : FN_SPARE_B;

        base = $urandom_range(0, 15);
        slot = stp_pkg::SLOT_FIELD_W'(base);
        // Walking downward leaves the first acquired slot at or after base.
        if ($urandom_range(0, 3) != 0)
            for (int k = 15; k >= 0; k--)
                if (slot_acquired[(base + k) % stp_pkg::POOL_DEF])
                    slot = stp_pkg::SLOT_FIELD_W'((base + k) % stp_pkg::POOL_DEF);

        case ($urandom_range(0, 9))
            0: period = stp_pkg::STORE_W'($urandom_range(1, 65535));
            1: period = 16'hFFFF;
            default: period = stp_pkg::STORE_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
            0, 1: reps = 16'hFFFF;
            2: reps = stp_pkg::STORE_W'($urandom_range(0, 32767));
            default: reps = stp_pkg::STORE_W'($urandom_range(0, 3));
        endcase
        issue_op(func, slot, period, reps, 1'b0, '0);
    endtask

    // Stops offering and waits until every owed result has been seen.
    task automatic wait_for_owed();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    // -------------------------------------------------------------------------
    // Stimulus.
    // -------------------------------------------------------------------------
    initial begin
        t_pool_event typed_ev;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_func         <= stp_pkg::FN_TICK;
        i_slot         <= '0;
        i_period       <= '0;
        i_repeat_count <= '0;
        foreach (slot_acquired[s]) begin
            slot_acquired[s] = 1'b0;
            slot_running[s]  = 1'b0;
            slot_period[s]   = '0;
            slot_reps[s]     = '0;
            slot_ticks[s]    = '0;
            slot_loops[s]    = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening walkthrough.
        foreach (opening_plan[r]) begin
            typed_ev = '{opening_plan[r].kind, opening_plan[r].slot_out, 1'b1};
            issue_op(opening_plan[r].func, opening_plan[r].slot, opening_plan[r].period,
                     opening_plan[r].reps, opening_plan[r].has_typed, typed_ev);
        end
        wait_for_owed();

        // First random mix. The receiver is asked for one long hold-off here,
        // while the sender keeps pushing, so the block backs up into its input.
        long_hold_due = 1'b1;
        repeat (17) issue_random_op();
        wait_for_owed();

        // Full pool: free every slot, fill the pool with one-tick timers and
        // one acquire too many, start them all and tick. The first tick fires
        // all sixteen timers in one item.
        for (int s = 0; s < stp_pkg::POOL_DEF; s++)
            issue_op(stp_pkg::FN_RELEASE, stp_pkg::SLOT_FIELD_W'(s), '0, '0, 1'b0, '0);
        repeat (stp_pkg::POOL_DEF + 1)
            issue_op(stp_pkg::FN_ACQUIRE, stp_pkg::SLOT_FIELD_W'($urandom_range(0, 15)), 16'd1,
                     stp_pkg::STORE_W'($urandom_range(0, 3)) - 16'd1, 1'b0, '0);
        for (int s = 0; s < stp_pkg::POOL_DEF; s++)
            issue_op(stp_pkg::FN_START, stp_pkg::SLOT_FIELD_W'(s), '0, '0, 1'b0, '0);
        repeat (3) issue_op(stp_pkg::FN_TICK, '0, '0, '0, 1'b0, '0);

        // Second random mix, starting from a crowded pool.
        repeat (17) issue_random_op();
        wait_for_owed();

        // Let a full tick walk pass in case the block has anything left to say.
        repeat (2 * stp_pkg::POOL_DEF + 8) @(posedge i_clk);

        $display("Covered %0d operation transactions and %0d result transactions.",
                 ops_sent, results_seen);
        $display("Timers fired %0d times (up to %0d in one tick), %0d grants, %0d refusals.",
                 fired_seen, widest_tick, granted_seen, refused_seen);
        if (error_count == 0)
            $display("software_timer_pool_top_test passed");
        else
            $display("software_timer_pool_top_test failed");
        $finish;
    end

    // -------------------------------------------------------------------------
    // Receiver. Stall behavior changes every segment: never, light, half or
    // heavy. Once per run, when asked, it refuses results for a long stretch.
    // -------------------------------------------------------------------------
    initial begin
        int seg_len;
        int stall_pct;
        i_out_stall <= 1'b0;
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                repeat (LONG_HOLD) begin
                    @(posedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            seg_len = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 90;
            endcase
            repeat (seg_len) begin
                @(posedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // -------------------------------------------------------------------------
    // Result checker. Every accepted result transaction is compared with the
    // oldest owed result. Printing stops after a few dozen errors so that a
    // badly broken block cannot flood the log, but every error is counted.
    // -------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pool_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                if (error_count < ERROR_PRINTS)
                    $display("[%0t] unexpected result: kind %0d slot %0d last %0d",
                             $time, o_kind, o_slot_out, o_last);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                case (want.kind)
                    stp_pkg::KD_FIRED:   fired_seen++;
                    stp_pkg::KD_GRANTED: granted_seen++;
                    stp_pkg::KD_FAILED:  refused_seen++;
                    default:             ;
                endcase
                if (o_kind !== want.kind || o_slot_out !== want.slot || o_last !== want.last) begin
                    if (error_count < ERROR_PRINTS)
                        $display("[%0t] mismatch kind/slot/last: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.kind, want.slot, want.last,
                                 o_kind, o_slot_out, o_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results still owed.",
                     cycle_count, owed_results.size());
            $display("software_timer_pool_top_test failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_ram.sv
rtl/stp_ctrl.sv
rtl/stp_dp.sv
rtl/software_timer_pool_top.sv
dv/software_timer_pool_top_test.sv
